[rtl/bsc_pkg.sv]
// Shared types, codes and constants of the balanced symbol checker.
`timescale 1ns / 1ps

package bsc_pkg;

    localparam int DEF_STACK_DEPTH   = 128;
    localparam int DEF_POSITION_BITS = 16;

    localparam int CHAR_W     = 8;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int OUT_POS_W  = 16;
    localparam int OUT_CNT_W  = 8;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    localparam int OUT_POS_LSB = STATUS_W;
    localparam int OUT_CNT_LSB = STATUS_W + OUT_POS_W;
    localparam int OUT_USED_W  = STATUS_W + OUT_POS_W + OUT_CNT_W;

    localparam logic [KIND_W-1:0] KIND_PAREN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BRACKET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BRACE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_COMMENT = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNCLOSED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    localparam logic [CHAR_W-1:0] CH_LPAREN   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN   = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACKET = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LBRACE   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE   = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [KIND_W-1:0] kind;
    } t_stk_ctl;

endpackage

[rtl/balanced_symbol_checker.sv]
// Top level of the balanced symbol checker: control and the cell-chain stack.
`timescale 1ns / 1ps

// Checks bracket and comment balance of a byte stream, one byte per cycle
// while s_axis_tready is high: every byte is decided in the cycle it is
// transferred, using the top cell of a shift-register stack of STACK_DEPTH
// cells that all move one place on a push or pop. On the byte flagged by
// s_axis_tlast the verdict (status, first-error position, unclosed count)
// appears on the master side in the next cycle; per-string state is cleared.
// The output register holds one verdict; the slave side stalls only while
// that verdict waits and m_axis_tready is low. No clearing pass after reset.

module balanced_symbol_checker
    import bsc_pkg::*;
#(
    parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] char_in
    input  logic                  s_axis_tlast,   // end_of_string
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [2:0] status, [18:3] error_position,
                                                  // [26:19] unclosed_count, [31:27] zero
);

    t_stk_ctl             w_stk;
    logic [KIND_W-1:0]    w_kind [STACK_DEPTH];
    logic [STATUS_W-1:0]  w_status;
    logic [OUT_POS_W-1:0] w_position;
    logic [OUT_CNT_W-1:0] w_count;

    bsc_ctrl #(
        .STACK_DEPTH   (STACK_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_char      (s_axis_tdata[CHAR_W-1:0]),
        .i_last      (s_axis_tlast),
        .i_top       (w_kind[0]),
        .o_stk       (w_stk),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_position  (w_position),
        .o_count     (w_count)
    );

    generate
        for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [KIND_W-1:0] w_above;
            logic [KIND_W-1:0] w_below;
            if (gi == 0) begin : g_head
                assign w_above = w_stk.kind;
            end else begin : g_mid_above
                assign w_above = w_kind[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_tail
                assign w_below = w_kind[gi];
            end else begin : g_mid_below
                assign w_below = w_kind[gi+1];
            end
            bsc_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_stk),
                .i_above (w_above),
                .i_below (w_below),
                .o_kind  (w_kind[gi])
            );
        end
    endgenerate

    assign m_axis_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), w_count, w_position, w_status};

endmodule

[rtl/bsc_cell.sv]
// One stack cell: holds one symbol kind and shifts with its neighbors.
`timescale 1ns / 1ps

module bsc_cell
    import bsc_pkg::*;
(
    input  logic              i_clk,
    input  t_stk_ctl          i_ctl,
    input  logic [KIND_W-1:0] i_above,
    input  logic [KIND_W-1:0] i_below,
    output logic [KIND_W-1:0] o_kind
);

    logic [KIND_W-1:0] r_kind;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_kind <= i_above;
        end else if (i_ctl.pop) begin
            r_kind <= i_below;
        end
    end

    assign o_kind = r_kind;

endmodule

[rtl/bsc_ctrl.sv]
// Token decode, depth and error tracking, and the verdict output register.
`timescale 1ns / 1ps

module bsc_ctrl
    import bsc_pkg::*;
#(
    parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CHAR_W-1:0]     i_char,
    input  logic                  i_last,
    input  logic [KIND_W-1:0]     i_top,
    output t_stk_ctl              o_stk,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [OUT_POS_W-1:0]  o_position,
    output logic [OUT_CNT_W-1:0]  o_count
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    logic [DEPTH_W-1:0]       r_depth, n_depth;
    logic                     r_pend_slash, n_pend_slash;
    logic                     r_pend_star, n_pend_star;
    logic                     r_err, n_err;
    logic [STATUS_W-1:0]      r_err_code, n_err_code;
    logic [POSITION_BITS-1:0] r_err_idx, n_err_idx;
    logic [POSITION_BITS-1:0] r_byte_idx, n_byte_idx;
    logic                     r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic [OUT_POS_W-1:0]     r_position, n_position;
    logic [OUT_CNT_W-1:0]     r_count, n_count;

    logic                     w_accept;
    logic                     w_open;
    logic                     w_close;
    logic [KIND_W-1:0]        w_kind;
    logic                     w_set_slash;
    logic                     w_set_star;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_open      = 1'b0;
        w_close     = 1'b0;
        w_kind      = KIND_PAREN;
        w_set_slash = 1'b0;
        w_set_star  = 1'b0;
        if (r_pend_slash && i_char == CH_STAR) begin
            w_open = 1'b1;
            w_kind = KIND_COMMENT;
        end else if (r_pend_star && i_char == CH_SLASH) begin
            w_close = 1'b1;
            w_kind  = KIND_COMMENT;
        end else begin
            unique case (i_char)
                CH_LPAREN: begin
                    w_open = 1'b1;
                    w_kind = KIND_PAREN;
                end
                CH_LBRACKET: begin
                    w_open = 1'b1;
                    w_kind = KIND_BRACKET;
                end
                CH_LBRACE: begin
                    w_open = 1'b1;
                    w_kind = KIND_BRACE;
                end
                CH_RPAREN: begin
                    w_close = 1'b1;
                    w_kind  = KIND_PAREN;
                end
                CH_RBRACKET: begin
                    w_close = 1'b1;
                    w_kind  = KIND_BRACKET;
                end
                CH_RBRACE: begin
                    w_close = 1'b1;
                    w_kind  = KIND_BRACE;
                end
                CH_SLASH: w_set_slash = 1'b1;
                CH_STAR:  w_set_star  = 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_depth      = r_depth;
        n_pend_slash = r_pend_slash;
        n_pend_star  = r_pend_star;
        n_err        = r_err;
        n_err_code   = r_err_code;
        n_err_idx    = r_err_idx;
        n_byte_idx   = r_byte_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_status     = r_status;
        n_position   = r_position;
        n_count      = r_count;
        o_stk.push   = 1'b0;
        o_stk.pop    = 1'b0;
        o_stk.kind   = w_kind;

        if (w_accept) begin
            if (!r_err) begin
                n_pend_slash = w_set_slash;
                n_pend_star  = w_set_star;
                if (w_open) begin
                    if (r_depth == DEPTH_W'(STACK_DEPTH)) begin
                        n_err      = 1'b1;
                        n_err_code = ST_OVERFLOW;
                        n_err_idx  = r_byte_idx;
                    end else begin
                        o_stk.push = 1'b1;
                        n_depth    = r_depth + 1'b1;
                    end
                end else if (w_close) begin
                    if (r_depth == '0) begin
                        n_err      = 1'b1;
                        n_err_code = ST_EMPTY;
                        n_err_idx  = r_byte_idx;
                    end else begin
                        o_stk.pop = 1'b1;
                        n_depth   = r_depth - 1'b1;
                        if (i_top != w_kind) begin
                            n_err      = 1'b1;
                            n_err_code = ST_MISMATCH;
                            n_err_idx  = r_byte_idx;
                        end
                    end
                end
            end
            n_byte_idx = r_byte_idx + 1'b1;

            if (i_last) begin
                n_out_valid = 1'b1;
                if (n_err) begin
                    n_status   = n_err_code;
                    n_position = OUT_POS_W'(n_err_idx);
                end else if (n_depth != '0) begin
                    n_status   = ST_UNCLOSED;
                    n_position = OUT_POS_W'(r_byte_idx);
                end else begin
                    n_status   = ST_OK;
                    n_position = '0;
                end
                n_count      = (32'(n_depth) > 32'd255) ? OUT_CNT_W'(255)
                                                         : OUT_CNT_W'(n_depth);
                n_depth      = '0;
                n_pend_slash = 1'b0;
                n_pend_star  = 1'b0;
                n_err        = 1'b0;
                n_err_code   = ST_OK;
                n_err_idx    = '0;
                n_byte_idx   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_pend_slash <= 1'b0;
            r_pend_star  <= 1'b0;
            r_err        <= 1'b0;
            r_err_code   <= ST_OK;
            r_err_idx    <= '0;
            r_byte_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_depth      <= n_depth;
            r_pend_slash <= n_pend_slash;
            r_pend_star  <= n_pend_star;
            r_err        <= n_err;
            r_err_code   <= n_err_code;
            r_err_idx    <= n_err_idx;
            r_byte_idx   <= n_byte_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_position <= n_position;
        r_count    <= n_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_position  = r_position;
    assign o_count     = r_count;

endmodule

[rtl/bsc_checker.sv]
// Port-level assertions for the balanced symbol checker, bound to the top level.
`timescale 1ns / 1ps

module bsc_checker
    import bsc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict changed while stalled");

    a_verdict_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("verdict without a last-byte transfer");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting verdict");

    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[STATUS_W-1:0] == ST_OK
        |-> m_axis_tdata[OUT_USED_W-1:OUT_POS_LSB] == '0)
        else $error("balanced verdict with nonzero position or count");

    a_unclosed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[STATUS_W-1:0] == ST_UNCLOSED
        |-> m_axis_tdata[OUT_USED_W-1:OUT_CNT_LSB] != '0)
        else $error("unclosed verdict with zero count");

endmodule

bind balanced_symbol_checker bsc_checker u_bsc_checker (.*);
